FILE: rtl/core/lpht_pkg.sv
// Shared types and codes for the linear-probe hash table.
// No dependencies; used by the hash unit and the top level.
`default_nettype none

package lpht_pkg;

    // Key width of a request and of a stored entry
    localparam int KEY_W = 31;

    // Width of the slot field in a result beat
    localparam int SLOT_OUT_W = 4;

    // Request operations
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2
    } t_cmd;

    // Per-slot status
    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_USED    = 2'd1,
        ST_DELETED = 2'd2
    } t_slot_st;

    // Result status codes
    localparam logic RSP_SUCCESS = 1'b0;
    localparam logic RSP_FAILURE = 1'b1;

    // One table entry as stored in the slot memory
    typedef struct packed {
        logic [KEY_W-1:0] key;
        t_slot_st         st;
    } t_entry;

endpackage

`default_nettype wire

FILE: rtl/core/lpht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/lpht_hash.sv
// Home-slot unit: key modulo SLOTS by reciprocal multiply and one correction.
// Depends on lpht_pkg (key width). Two register stages; the result is read from the second.
`default_nettype none

module lpht_hash #(
    parameter int SLOTS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [lpht_pkg::KEY_W-1:0]  i_key,
    output logic                             o_valid,
    output logic      [$clog2(SLOTS)-1:0]    o_home
);

    localparam int AW    = $clog2(SLOTS);
    localparam int KW    = lpht_pkg::KEY_W;
    localparam int PW    = KW + 32;
    // floor(2^32 / SLOTS); quotient estimate is exact or one short
    localparam longint unsigned RECIP_L = (64'd1 << 32) / SLOTS;
    localparam logic [31:0]     RECIP   = 32'(RECIP_L);
    localparam logic [KW-1:0]   SLOTS_K = KW'(SLOTS);
    localparam logic [AW:0]     SLOTS_R = (AW + 1)'(SLOTS);

    logic          r_v1;
    logic          r_v2;
    logic [KW-1:0] r_key1;
    logic [PW-1:0] r_prod;
    logic [AW:0]   r_rem;

    logic [KW-1:0] quot;
    logic [KW-1:0] back;
    logic [KW-1:0] diff;
    logic [AW:0]   fixed;

    // Quotient estimate and remainder estimate below twice SLOTS
    assign quot = r_prod[PW-1:32];
    assign back = quot * SLOTS_K;
    assign diff = r_key1 - back;

    // Fold the remainder estimate into range
    assign fixed  = (r_rem >= SLOTS_R) ? (r_rem - SLOTS_R) : r_rem;
    assign o_home = fixed[AW-1:0];
    assign o_valid = r_v2;

    // Advance the valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Multiply by reciprocal, then back-multiply and subtract
    always_ff @(posedge i_clk) begin
        r_key1 <= i_key;
        r_prod <= PW'(i_key) * PW'(RECIP);
        r_rem  <= diff[AW:0];
    end

endmodule

`default_nettype wire

FILE: rtl/core/linear_probe_hash_table.sv
// Top level of the linear-probe hash table: request FSM, probe walk, result register.
// Depends on lpht_pkg, lpht_hash and lpht_ram.
//
//  channel | dir | tdata                   | tuser
//  --------+-----+-------------------------+-------------------
//  s       | in  | [30:0] key, [31] zero   | [1:0] cmd
//  m       | out | [3:0] slot, [7:4] zero  | [0] status
//
// A request passes the accept, then the home-slot unit, then one memory read per probe for
// P slots, where P (1..SLOTS) is the number of slots probed.
// The probe walk is bound by the single read port of the slot memory.
// After reset a clearing pass writes every slot in turn as empty; no request is
// taken meanwhile. A new request is taken while a result waits; a finished probe holds
// in place while the result register is still full and not taken.
`default_nettype none

module linear_probe_hash_table #(
    parameter int SLOTS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [30:0] key, [31] zero
    input  wire logic [1:0]  i_s_tuser,   // [1:0] cmd
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic      [7:0] o_m_tdata,    // [3:0] slot, [7:4] zero
    output logic      [0:0] o_m_tuser     // [0] status
);

    localparam int            AW        = $clog2(SLOTS);
    localparam int            KW        = lpht_pkg::KEY_W;
    localparam int            SW        = lpht_pkg::SLOT_OUT_W;
    localparam int            EW        = $bits(lpht_pkg::t_entry);
    localparam logic [AW-1:0] ADDR_LAST = AW'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_addr, n_addr;
    lpht_pkg::t_cmd    r_cmd, n_cmd;
    logic [KW-1:0]     r_key, n_key;
    logic              r_out_valid, n_out_valid;
    logic              r_out_status, n_out_status;
    logic [SW-1:0]     r_out_slot, n_out_slot;

    logic              accept;
    logic              hash_valid;
    logic [AW-1:0]     hash_home;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    lpht_pkg::t_entry  mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [EW-1:0]     mem_rdata;
    lpht_pkg::t_entry  rd_entry;
    logic [AW-1:0]     next_addr;
    logic              last_probe;
    logic              probe_done;
    logic              probe_hit;
    logic              probe_wr;
    lpht_pkg::t_entry  probe_wdata;
    logic              out_free;
    logic [AW+SW-1:0]  slot_ext;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(8 - SW){1'b0}}, r_out_slot};
    assign o_m_tuser  = r_out_status;

    assign rd_entry   = lpht_pkg::t_entry'(mem_rdata);
    assign next_addr  = (r_addr == ADDR_LAST) ? '0 : r_addr + 1'b1;
    assign last_probe = (r_cnt == ADDR_LAST);
    assign out_free   = !r_out_valid || i_m_tready;
    assign slot_ext   = (AW + SW)'(r_addr);

    lpht_hash #(
        .SLOTS (SLOTS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_key   (i_s_tdata[KW-1:0]),
        .o_valid (hash_valid),
        .o_home  (hash_home)
    );

    lpht_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (1'b1),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Judge the slot whose entry the memory returns this cycle
    always_comb begin
        probe_done  = 1'b0;
        probe_hit   = 1'b0;
        probe_wr    = 1'b0;
        probe_wdata = rd_entry;
        case (r_cmd)
            lpht_pkg::CMD_ADD: begin
                if (rd_entry.st != lpht_pkg::ST_USED) begin
                    probe_done      = 1'b1;
                    probe_hit       = 1'b1;
                    probe_wr        = 1'b1;
                    probe_wdata.key = r_key;
                    probe_wdata.st  = lpht_pkg::ST_USED;
                end else if (last_probe) begin
                    probe_done = 1'b1;
                end
            end
            lpht_pkg::CMD_DELETE, lpht_pkg::CMD_SEARCH: begin
                if (rd_entry.st == lpht_pkg::ST_EMPTY) begin
                    probe_done = 1'b1;
                end else if (rd_entry.st == lpht_pkg::ST_USED && rd_entry.key == r_key) begin
                    probe_done     = 1'b1;
                    probe_hit      = 1'b1;
                    probe_wr       = (r_cmd == lpht_pkg::CMD_DELETE);
                    probe_wdata.st = lpht_pkg::ST_DELETED;
                end else if (last_probe) begin
                    probe_done = 1'b1;
                end
            end
            default: begin
                probe_done = 1'b1;
            end
        endcase
    end

    // Sequence clear, hash, probe and result load
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_addr       = r_addr;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        mem_we       = 1'b0;
        mem_waddr    = r_addr;
        mem_wdata    = probe_wdata;
        mem_raddr    = r_addr;
        case (r_state)
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = r_cnt;
                mem_wdata.key = '0;
                mem_wdata.st  = lpht_pkg::ST_EMPTY;
                n_cnt        = r_cnt + 1'b1;
                if (last_probe) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd   = lpht_pkg::t_cmd'(i_s_tuser);
                    n_key   = i_s_tdata[KW-1:0];
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_valid) begin
                    mem_raddr = hash_home;
                    n_addr    = hash_home;
                    n_cnt     = '0;
                    n_state   = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!probe_done) begin
                    mem_raddr = next_addr;
                    n_addr    = next_addr;
                    n_cnt     = r_cnt + 1'b1;
                end else if (out_free) begin
                    mem_we       = probe_wr;
                    n_out_valid  = 1'b1;
                    n_out_status = probe_hit ? lpht_pkg::RSP_SUCCESS : lpht_pkg::RSP_FAILURE;
                    n_out_slot   = probe_hit ? slot_ext[SW-1:0] : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_addr       <= n_addr;
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

    // A failed request reports slot zero
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == lpht_pkg::RSP_FAILURE) |-> (r_out_slot == '0))
        else $error("failed result with nonzero slot");

    // The home-slot unit answers only while a request waits for it
    a_hash_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_valid |-> (r_state == S_HASH))
        else $error("home slot arrived outside hash wait");

    // A probe that goes on steps its counter by one
    a_probe_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && !probe_done) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("probe counter did not advance");

endmodule

`default_nettype wire
